>>> sv/rc4_stream_cipher_macros.svh
// ============================================================================
// RC4 stream cipher assertion macros
// Shared property shorthands for the checker of the RC4 block.
// ============================================================================
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define RC4_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Implication checked in the next cycle.
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked in the same cycle.
`define RC4_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/rc4_pkg.sv
// ============================================================================
// RC4 package
// Types and constants shared by the RC4 stream cipher modules.
// ============================================================================
`default_nettype none

package rc4_pkg;

    localparam int PERM_DEPTH      = 256;
    localparam int PERM_AW         = 8;
    localparam int KEY_MAX_DEFAULT = 64;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       keyed;
    } rc4_result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_K_RD,
        ST_K_ACC,
        ST_K_W1,
        ST_K_W2,
        ST_P_J,
        ST_P_SW1,
        ST_P_SW2,
        ST_HOLD
    } rc4_state_t;

endpackage

`default_nettype wire

>>> sv/rc4_stream_cipher.sv
// ============================================================================
// RC4 stream cipher
// Key loading, key schedule and keystream XOR around one permutation memory.
// ============================================================================
// Usage:
// The input channel (in_valid/in_ready) carries op, data_byte and last. A key
// transaction (op = 0) stores one key byte; bytes beyond KEY_MAX are dropped.
// A key transaction with last set starts the key schedule, which holds
// in_ready low through one fill pass over the permutation memory, then, per
// entry, a read, the index update and a two-write swap through its single
// read and single write port.
// A data transaction (op = 1) gives one result on the output channel
// (out_valid/out_ready) with result_byte and keyed. Once keyed, each byte
// goes through a chain of dependent memory reads and the swap writes before
// it reaches the output register; the block takes no new byte until then.
// Before any key schedule, data passes unchanged with keyed low.
// Key transactions produce no result. The output register lets the next
// transaction be taken while a result waits. If the receiver stalls longer,
// the core parks its result and holds in_ready low until the register frees
// up. Reset clears indices, the key count and the keyed flag; the memories
// need no clearing.
// ============================================================================
`default_nettype none

module rc4_stream_cipher
    import rc4_pkg::*;
#(
    parameter int KEY_MAX = KEY_MAX_DEFAULT
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       op,
    input  wire logic [7:0] data_byte,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      result_byte,
    output logic            keyed
);

    logic        push_valid;
    logic        push_ready;
    rc4_result_t push_data;

    // Sequencer with the permutation and key memories.
    rc4_core #(
        .KEY_MAX (KEY_MAX)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .data_byte  (data_byte),
        .last       (last),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Output register that decouples the receiver from the core.
    rc4_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_byte (result_byte),
        .keyed       (keyed)
    );

endmodule

`default_nettype wire

>>> sv/rc4_core.sv
// ============================================================================
// RC4 core
// Sequencer around the permutation memory and the key memory: key loading,
// key schedule and keystream generation.
// ============================================================================
`default_nettype none

module rc4_core
    import rc4_pkg::*;
#(
    parameter int KEY_MAX = KEY_MAX_DEFAULT
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last,
    output logic             push_valid,
    input  wire logic        push_ready,
    output rc4_result_t      push_data
);

    localparam int CNT_W = $clog2(KEY_MAX + 1);
    localparam int KA_W  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int CW1   = CNT_W + 1;

    // Memories: written and read synchronously, read data registered.
    logic [7:0] perm_mem [PERM_DEPTH];
    logic [7:0] key_mem  [KEY_MAX];

    logic               perm_we;
    logic [PERM_AW-1:0] perm_waddr;
    logic [7:0]         perm_wdata;
    logic [PERM_AW-1:0] perm_raddr;
    logic [7:0]         perm_rdata_reg;
    logic               key_we;
    logic [7:0]         key_rdata_reg;

    rc4_state_t         state_reg, state_next;
    logic [7:0]         i_reg, i_next;
    logic [7:0]         j_reg, j_next;
    logic               keyed_reg, keyed_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [7:0]         n_reg, n_next;
    logic [7:0]         acc_reg, acc_next;
    logic [KA_W-1:0]    kidx_reg, kidx_next;
    logic [7:0]         si_reg, si_next;
    logic [7:0]         sj_reg, sj_next;
    logic               fwd_i_reg, fwd_i_next;
    logic               fwd_j_reg, fwd_j_next;
    logic [7:0]         dbyte_reg, dbyte_next;
    rc4_result_t        hold_reg, hold_next;

    logic [7:0]         key_byte;
    logic [7:0]         sum_t;
    logic [7:0]         ks_byte;
    logic [CW1-1:0]     kidx_inc;
    rc4_result_t        res_now;

    always_ff @(posedge clk)
    begin
        if (perm_we)
        begin
            perm_mem[perm_waddr] <= perm_wdata;
        end
        perm_rdata_reg <= perm_mem[perm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[count_reg[KA_W-1:0]] <= data_byte;
        end
        key_rdata_reg <= key_mem[kidx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            keyed_reg <= 1'b0;
            count_reg <= '0;
            n_reg     <= '0;
            acc_reg   <= '0;
            kidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            keyed_reg <= keyed_next;
            count_reg <= count_next;
            n_reg     <= n_next;
            acc_reg   <= acc_next;
            kidx_reg  <= kidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg    <= si_next;
        sj_reg    <= sj_next;
        fwd_i_reg <= fwd_i_next;
        fwd_j_reg <= fwd_j_next;
        dbyte_reg <= dbyte_next;
        hold_reg  <= hold_next;
    end

    // An empty key schedules as a single zero byte.
    assign key_byte = (count_reg == '0) ? 8'd0 : key_rdata_reg;
    assign kidx_inc = CW1'(kidx_reg) + CW1'(1);
    assign sum_t    = si_reg + perm_rdata_reg;

    // The last swap write lands in the same cycle as the keystream read.
    always_comb
    begin
        priority if (fwd_j_reg)
        begin
            ks_byte = si_reg;
        end
        else if (fwd_i_reg)
        begin
            ks_byte = sj_reg;
        end
        else
        begin
            ks_byte = perm_rdata_reg;
        end
    end

    assign res_now.result_byte = dbyte_reg ^ ks_byte;
    assign res_now.keyed       = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        keyed_next = keyed_reg;
        count_next = count_reg;
        n_next     = n_reg;
        acc_next   = acc_reg;
        kidx_next  = kidx_reg;
        si_next    = si_reg;
        sj_next    = sj_reg;
        fwd_i_next = fwd_i_reg;
        fwd_j_next = fwd_j_reg;
        dbyte_next = dbyte_reg;
        hold_next  = hold_reg;
        perm_we    = 1'b0;
        perm_waddr = n_reg;
        perm_wdata = n_reg;
        perm_raddr = i_reg + 8'd1;
        key_we     = 1'b0;
        in_ready   = 1'b0;
        push_valid = 1'b0;
        push_data  = hold_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (op == OP_KEY)
                    begin
                        if (count_reg < CNT_W'(KEY_MAX))
                        begin
                            key_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        if (last)
                        begin
                            n_next     = '0;
                            state_next = ST_INIT;
                        end
                    end
                    else if (keyed_reg)
                    begin
                        i_next     = i_reg + 8'd1;
                        dbyte_next = data_byte;
                        state_next = ST_P_J;
                    end
                    else
                    begin
                        hold_next.result_byte = data_byte;
                        hold_next.keyed       = 1'b0;
                        state_next            = ST_HOLD;
                    end
                end
            end
            ST_INIT:
            begin
                perm_we    = 1'b1;
                n_next     = n_reg + 8'd1;
                if (n_reg == 8'(PERM_DEPTH - 1))
                begin
                    acc_next   = '0;
                    kidx_next  = '0;
                    state_next = ST_K_RD;
                end
            end
            ST_K_RD:
            begin
                perm_raddr = n_reg;
                state_next = ST_K_ACC;
            end
            ST_K_ACC:
            begin
                acc_next   = acc_reg + perm_rdata_reg + key_byte;
                perm_raddr = acc_reg + perm_rdata_reg + key_byte;
                si_next    = perm_rdata_reg;
                state_next = ST_K_W1;
            end
            ST_K_W1:
            begin
                perm_we    = 1'b1;
                perm_wdata = perm_rdata_reg;
                state_next = ST_K_W2;
            end
            ST_K_W2:
            begin
                perm_we    = 1'b1;
                perm_waddr = acc_reg;
                perm_wdata = si_reg;
                n_next     = n_reg + 8'd1;
                if (kidx_inc >= CW1'(count_reg))
                begin
                    kidx_next = '0;
                end
                else
                begin
                    kidx_next = kidx_inc[KA_W-1:0];
                end
                if (n_reg == 8'(PERM_DEPTH - 1))
                begin
                    i_next     = '0;
                    j_next     = '0;
                    keyed_next = 1'b1;
                    count_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_K_RD;
                end
            end
            ST_P_J:
            begin
                si_next    = perm_rdata_reg;
                j_next     = j_reg + perm_rdata_reg;
                perm_raddr = j_reg + perm_rdata_reg;
                state_next = ST_P_SW1;
            end
            ST_P_SW1:
            begin
                perm_we    = 1'b1;
                perm_waddr = i_reg;
                perm_wdata = perm_rdata_reg;
                perm_raddr = sum_t;
                sj_next    = perm_rdata_reg;
                fwd_i_next = (sum_t == i_reg);
                fwd_j_next = (sum_t == j_reg);
                state_next = ST_P_SW2;
            end
            ST_P_SW2:
            begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = si_reg;
                push_valid = 1'b1;
                push_data  = res_now;
                if (push_ready)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    hold_next  = res_now;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/rc4_out_buf.sv
// ============================================================================
// RC4 output buffer
// One-entry output register between the core and the result channel.
// ============================================================================
`default_nettype none

module rc4_out_buf
    import rc4_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push_valid,
    output logic             push_ready,
    input  wire rc4_result_t push_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       result_byte,
    output logic             keyed
);

    logic        valid_reg, valid_next;
    rc4_result_t data_reg;

    assign push_ready = !valid_reg || out_ready;

    always_comb
    begin
        priority if (push_valid && push_ready)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
        begin
            data_reg <= push_data;
        end
    end

    assign out_valid   = valid_reg;
    assign result_byte = data_reg.result_byte;
    assign keyed       = data_reg.keyed;

endmodule

`default_nettype wire

>>> sv/rc4_checker.sv
// ============================================================================
// RC4 port checker
// Assertions on the ports of the RC4 stream cipher, attached by bind.
// ============================================================================
`default_nettype none

`include "rc4_stream_cipher_macros.svh"

module rc4_checker
    import rc4_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       op,
    input wire logic [7:0] data_byte,
    input wire logic       last,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] result_byte,
    input wire logic       keyed
);

    logic seen_keyed_reg;

    // Remembers that a keyed result has left the block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_keyed_reg <= 1'b0;
        end
        else if (out_valid && out_ready && keyed)
        begin
            seen_keyed_reg <= 1'b1;
        end
    end

    `RC4_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(result_byte) && $stable(keyed),
        "result changed or dropped while stalled")

    `RC4_ASSERT_NEXT(a_data_busy, in_valid && in_ready && (op == OP_DATA), !in_ready,
        "input still ready right after a data transaction")

    `RC4_ASSERT_SAME(a_result_origin, $rose(out_valid), !$past(in_ready),
        "result appeared without the core being busy")

    `RC4_ASSERT_ALWAYS(a_keyed_sticky, !(out_valid && seen_keyed_reg) || keyed,
        "unkeyed result after a keyed one")

    // Transaction fields not covered by the properties above.
    logic unused_ok;
    assign unused_ok = ^{data_byte, last};

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .data_byte   (data_byte),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_byte (result_byte),
    .keyed       (keyed)
);

`default_nettype wire
